>>> rtl/hpnp_pkg.sv
// constants, types and small tables for the nested pixel-centre to vector core
// used by healpix_nested_pixel_to_vector_core; no dependencies
`default_nettype none

package hpnp_pkg;

  localparam int MAX_ORDER     = 13;
  localparam int OUT_FRAC_BITS = 30;
  localparam int WF            = 30;
  localparam int NUM_ITER      = 32;
  localparam int NUM_CORDIC    = 30;

  localparam logic [29:0] PI4_Q  = 30'd843314857;
  localparam logic [29:0] GAIN_Q = 30'd652032874;
  // multiply-by-reciprocal of three, exact for any 32-bit operand after >> 33
  localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

  localparam int OUT_SHL = (OUT_FRAC_BITS >= WF) ? OUT_FRAC_BITS - WF : 0;
  localparam int OUT_SHR = (OUT_FRAC_BITS < WF) ? WF - OUT_FRAC_BITS : 0;
  localparam logic signed [63:0] OUT_HALF =
    (OUT_SHR > 0) ? (64'sd1 <<< (OUT_SHR - 1)) : 64'sd0;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef struct packed {
    logic               err;
    logic               yneg;
    logic               polar;
    logic               dneg;
    logic [13:0]        s;
    logic [13:0]        ad;
    logic [32:0]        phi_base;
    logic signed [31:0] zq;
  } hpnp_carry_t;

  typedef struct packed {
    logic               err;
    logic [1:0]         q;
    logic signed [31:0] zq;
  } hpnp_tail_t;

  function automatic logic [2:0] face_col(input logic [3:0] face);
    logic [2:0] c;
    case (face)
      4'd0, 4'd8:  c = 3'd1;
      4'd1, 4'd9:  c = 3'd3;
      4'd2, 4'd10: c = 3'd5;
      4'd3, 4'd11: c = 3'd7;
      4'd4:        c = 3'd0;
      4'd5:        c = 3'd2;
      4'd6:        c = 3'd4;
      4'd7:        c = 3'd6;
      default:     c = 3'd0;
    endcase
    return c;
  endfunction

  // magnitude of the (non-positive) face row
  function automatic logic [1:0] face_row_mag(input logic [3:0] face);
    logic [1:0] r;
    case (face) inside
      [4'd0:4'd3]:  r = 2'd0;
      [4'd4:4'd7]:  r = 2'd1;
      [4'd8:4'd11]: r = 2'd2;
      default:      r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h3243F6A9;
      5'd1:    a = 32'h1DAC6705;
      5'd2:    a = 32'h0FADBAFD;
      5'd3:    a = 32'h07F56EA7;
      5'd4:    a = 32'h03FEAB77;
      5'd5:    a = 32'h01FFD55C;
      5'd6:    a = 32'h00FFFAAB;
      5'd7:    a = 32'h007FFF55;
      5'd8:    a = 32'h003FFFEB;
      5'd9:    a = 32'h001FFFFD;
      default: a = 32'h0010_0000 >> (i - 5'd10);
    endcase
    return a;
  endfunction

  // q.30 to output scaling, low 32 bits kept
  function automatic logic [31:0] to_out(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (OUT_FRAC_BITS >= WF) begin
      w = w <<< OUT_SHL;
    end else begin
      w = (w + OUT_HALF) >>> OUT_SHR;
    end
    return w[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/healpix_nested_pixel_to_vector_core.sv
// nested pixel index to unit vector of the pixel centre, fully pipelined
// depends on hpnp_pkg (constants, face tables, arctangent table, output scaling)
//
//   channel   handshake                 payload
//   request   start / busy (busy = 0)   pixel_index
//   result    done strobe, one cycle    unit_x, unit_y, unit_z, index_error
//   config    cfg_valid / cfg_ready     cfg_data (nside_order)
//
// one request per cycle; done is registered from the end of the valid chain
// the pipeline holds a 32-stage root/divide array and a 30-stage cordic
// rst clears the valid chain and nside_order; data registers are not reset
// busy is always low and results cannot be held off, so nothing ever stalls
`default_nettype none

module healpix_nested_pixel_to_vector_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [29:0] pixel_index,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  output logic             done,
  output logic [31:0]      unit_x,
  output logic [31:0]      unit_y,
  output logic [31:0]      unit_z,
  output logic             index_error
);

  localparam int NI = hpnp_pkg::NUM_ITER;
  localparam int NC = hpnp_pkg::NUM_CORDIC;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic [3:0] nside_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      nside_order <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      nside_order <= cfg_data;
    end
  end

  // stage 0: capture
  logic        v0;
  logic [29:0] pix0;
  logic [3:0]  ord0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    pix0 <= pixel_index;
    ord0 <= (nside_order > 4'(hpnp_pkg::MAX_ORDER)) ? 4'(hpnp_pkg::MAX_ORDER) : nside_order;
  end

  // stage 1: face, morton split, projected position
  logic [29:0] face_full;
  logic [25:0] morton;
  logic [12:0] ix, iy;
  logic [2:0]  col;
  logic [1:0]  rowm;
  logic        v1, err1;
  logic [17:0] xn1, yn1;
  logic [3:0]  ord1;

  always_comb begin
    face_full = pix0 >> {ord0, 1'b0};
    morton    = pix0[25:0] & ~(26'h3FFFFFF << {ord0, 1'b0});
    for (int b = 0; b < 13; b++) begin
      ix[b] = morton[2*b];
      iy[b] = morton[2*b+1];
    end
    col  = hpnp_pkg::face_col(face_full[3:0]);
    rowm = hpnp_pkg::face_row_mag(face_full[3:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    err1 <= face_full > 30'd11;
    xn1  <= (18'(col) << ord0) + 18'(ix) - 18'(iy);
    yn1  <= 18'(ix) + 18'(iy) + 18'd1 - (18'(rowm) << ord0);
    ord1 <= ord0;
  end

  // stage 2: cap test, sigma, cap meridian
  logic [17:0] ay_full, ksum;
  logic [14:0] nside2;
  logic [2:0]  kq;
  logic        v2, err2, yneg2, polar2;
  logic [14:0] ay2;
  logic [13:0] s2;
  logic [4:0]  xc2;
  logic [17:0] xn2;
  logic [3:0]  ord2;

  always_comb begin
    ay_full = yn1[17] ? (18'd0 - yn1) : yn1;
    nside2  = 15'd1 << ord1;
    ksum    = xn1 + (18'(nside2) << 2);
    kq      = 3'(ksum >> (ord1 + 4'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    err2   <= err1;
    yneg2  <= yn1[17];
    ay2    <= ay_full[14:0];
    polar2 <= ay_full[14:0] > nside2;
    s2     <= 14'((nside2 << 1) - ay_full[14:0]);
    xc2    <= 5'({kq, 1'b0}) - 5'd3;
    xn2    <= xn1;
    ord2   <= ord1;
  end

  // stage 3: sigma squared, offset from meridian, equatorial phi
  logic [18:0] d3c;
  logic        dneg3c;
  logic [32:0] phi_eq;
  logic        v3;
  logic [27:0] sq3;
  logic [31:0] zeq3;
  logic [3:0]  ord3;
  hpnp_pkg::hpnp_carry_t c3;

  always_comb begin
    d3c    = {xn2[17], xn2} - ({{14{xc2[4]}}, xc2} << ord2);
    dneg3c = d3c[18];
    phi_eq = {{15{xn2[17]}}, xn2} << (5'd30 - {1'b0, ord2});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    sq3         <= 28'(s2) * 28'(s2);
    zeq3        <= 32'(ay2) << (5'd31 - {1'b0, ord2});
    ord3        <= ord2;
    c3.err      <= err2;
    c3.yneg     <= yneg2;
    c3.polar    <= polar2;
    c3.dneg     <= dneg3c;
    c3.s        <= s2;
    c3.ad       <= 14'(dneg3c ? (19'd0 - d3c) : d3c);
    c3.phi_base <= polar2 ? {xc2[2:0], 30'd0} : phi_eq;
    c3.zq       <= '0;
  end

  // stage 4: numerator of z over three
  logic        v4;
  logic [31:0] zn4;
  hpnp_pkg::hpnp_carry_t c4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    zn4 <= (c3.polar ? (32'(sq3) << (5'd30 - {ord3, 1'b0})) : zeq3) + 32'd1;
    c4  <= c3;
  end

  // stage 5: divide by three through the reciprocal
  logic [63:0] zprod;
  logic        v5;
  logic [30:0] t5;
  hpnp_pkg::hpnp_carry_t c5;

  assign zprod = 64'(zn4) * 64'(hpnp_pkg::RECIP3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    t5 <= zprod[63:33];
    c5 <= c4;
  end

  // stage 6: signed z
  logic [30:0] zm6c;
  logic        v6;
  logic [30:0] az6;
  hpnp_pkg::hpnp_carry_t c6c;
  hpnp_pkg::hpnp_carry_t c6;

  assign zm6c = c5.polar ? (31'h4000_0000 - t5) : t5;

  always_comb begin
    c6c    = c5;
    c6c.zq = c5.yneg ? $signed(32'd0 - {1'b0, zm6c}) : $signed({1'b0, zm6c});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    az6 <= zm6c;
    c6  <= c6c;
  end

  // stage 7: z squared
  logic        v7;
  logic [61:0] azsq7;
  hpnp_pkg::hpnp_carry_t c7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    azsq7 <= 62'(az6) * 62'(az6);
    c7    <= c6;
  end

  // root and divide array: index 0 is loaded here, one digit of each per stage
  logic                  it_v    [0:NI];
  logic [34:0]           it_rem  [0:NI];
  logic [31:0]           it_root [0:NI];
  logic [63:0]           it_n    [0:NI];
  logic [14:0]           it_drem [0:NI];
  logic [31:0]           it_dlow [0:NI];
  logic [31:0]           it_quo  [0:NI];
  hpnp_pkg::hpnp_carry_t it_c    [0:NI];

  always_ff @(posedge clk) begin
    if (rst) begin
      it_v[0] <= 1'b0;
    end else begin
      it_v[0] <= v7;
    end
    it_rem[0]  <= '0;
    it_root[0] <= '0;
    it_n[0]    <= 64'h1000_0000_0000_0000 - {2'b00, azsq7};
    it_drem[0] <= {2'b00, c7.ad[13:1]};
    it_dlow[0] <= {c7.ad[0], 17'd0, c7.s};
    it_quo[0]  <= '0;
    it_c[0]    <= c7;
  end

  for (genvar j = 0; j < NI; j++) begin : g_iter
    logic [34:0] rsh, trial;
    logic        ge;
    logic [15:0] dsh, den;
    logic        dge;

    always_comb begin
      rsh   = {it_rem[j][32:0], it_n[j][63:62]};
      trial = {1'b0, it_root[j], 2'b01};
      ge    = rsh >= trial;
      dsh   = {it_drem[j], it_dlow[j][31]};
      den   = {1'b0, it_c[j].s, 1'b0};
      dge   = dsh >= den;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        it_v[j+1] <= 1'b0;
      end else begin
        it_v[j+1] <= it_v[j];
      end
      it_rem[j+1]  <= ge ? (rsh - trial) : rsh;
      it_root[j+1] <= {it_root[j][30:0], ge};
      it_n[j+1]    <= it_n[j] << 2;
      it_drem[j+1] <= 15'(dge ? (dsh - den) : dsh);
      it_dlow[j+1] <= it_dlow[j] << 1;
      it_quo[j+1]  <= {it_quo[j][30:0], dge};
      it_c[j+1]    <= it_c[j];
    end
  end

  // post 1: cordic start amplitude, phi in eighths of a turn
  logic [32:0] quo33, phi_p;
  logic        vp1;
  logic [60:0] cxp1;
  logic [1:0]  q1;
  logic [30:0] r1;
  logic        err1p;
  logic signed [31:0] zq1p;

  always_comb begin
    quo33 = {1'b0, it_quo[NI]};
    if (!it_c[NI].polar) begin
      phi_p = it_c[NI].phi_base;
    end else if (it_c[NI].dneg) begin
      phi_p = it_c[NI].phi_base - quo33;
    end else begin
      phi_p = it_c[NI].phi_base + quo33;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
    end else begin
      vp1 <= it_v[NI];
    end
    cxp1  <= 61'(it_root[NI][30:0]) * 61'(hpnp_pkg::GAIN_Q) + 61'h2000_0000;
    q1    <= phi_p[32:31];
    r1    <= phi_p[30:0];
    err1p <= it_c[NI].err;
    zq1p  <= it_c[NI].zq;
  end

  // post 2: angle to radians
  logic        vp2;
  logic [30:0] cx2;
  logic [60:0] rp2;
  hpnp_pkg::hpnp_tail_t tl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp2 <= 1'b0;
    end else begin
      vp2 <= vp1;
    end
    cx2    <= cxp1[60:30];
    rp2    <= 61'(r1) * 61'(hpnp_pkg::PI4_Q) + 61'h2000_0000;
    tl2.err <= err1p;
    tl2.q   <= q1;
    tl2.zq  <= zq1p;
  end

  // rotation cordic, one micro-rotation per stage
  logic                 co_v  [0:NC];
  logic signed [32:0]   co_x  [0:NC];
  logic signed [32:0]   co_y  [0:NC];
  logic signed [33:0]   co_a  [0:NC];
  hpnp_pkg::hpnp_tail_t co_t  [0:NC];

  always_ff @(posedge clk) begin
    if (rst) begin
      co_v[0] <= 1'b0;
    end else begin
      co_v[0] <= vp2;
    end
    co_x[0] <= $signed({2'b00, cx2});
    co_y[0] <= '0;
    co_a[0] <= $signed({3'b000, rp2[60:30]});
    co_t[0] <= tl2;
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic signed [33:0] atn;

    assign atn = $signed({2'b00, hpnp_pkg::atan_val(5'(i))});

    always_ff @(posedge clk) begin
      if (rst) begin
        co_v[i+1] <= 1'b0;
      end else begin
        co_v[i+1] <= co_v[i];
      end
      if (!co_a[i][33]) begin
        co_x[i+1] <= co_x[i] - (co_y[i] >>> i);
        co_y[i+1] <= co_y[i] + (co_x[i] >>> i);
        co_a[i+1] <= co_a[i] - atn;
      end else begin
        co_x[i+1] <= co_x[i] + (co_y[i] >>> i);
        co_y[i+1] <= co_y[i] - (co_x[i] >>> i);
        co_a[i+1] <= co_a[i] + atn;
      end
      co_t[i+1] <= co_t[i];
    end
  end

  // clamp, quadrant rotation, output scaling
  localparam logic signed [32:0] ONE_Q = 33'sd1073741824;

  logic signed [31:0] cxc, cyc, ox, oy;

  always_comb begin
    if (co_x[NC] > ONE_Q) begin
      cxc = 32'sd1073741824;
    end else if (co_x[NC] < -ONE_Q) begin
      cxc = -32'sd1073741824;
    end else begin
      cxc = 32'(co_x[NC]);
    end
    if (co_y[NC] > ONE_Q) begin
      cyc = 32'sd1073741824;
    end else if (co_y[NC] < -ONE_Q) begin
      cyc = -32'sd1073741824;
    end else begin
      cyc = 32'(co_y[NC]);
    end
    case (co_t[NC].q)
      hpnp_pkg::QUAD_0: begin
        ox = cxc;
        oy = cyc;
      end
      hpnp_pkg::QUAD_1: begin
        ox = -cyc;
        oy = cxc;
      end
      hpnp_pkg::QUAD_2: begin
        ox = -cxc;
        oy = -cyc;
      end
      default: begin
        ox = cyc;
        oy = -cxc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= co_v[NC];
    end
    index_error <= co_t[NC].err;
    unit_x <= co_t[NC].err ? 32'd0 : hpnp_pkg::to_out(ox);
    unit_y <= co_t[NC].err ? 32'd0 : hpnp_pkg::to_out(oy);
    unit_z <= co_t[NC].err ? 32'd0 : hpnp_pkg::to_out(co_t[NC].zq);
  end

endmodule

`default_nettype wire
